/* rtl/fmpr_pkg.sv */
package fmpr_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CNT_W = 32;
	localparam int PPL_W = 16;
	localparam int DEB_W = 20;
	localparam int OUT_W = 48;

	localparam logic [15:0]    MS_PER_MIN = 16'd60000;
	localparam logic [OUT_W-1:0] OUT_MAX  = {OUT_W{1'b1}};

	// operation codes
	typedef logic [1:0] op_t;
	localparam op_t OP_EDGE  = 2'd0;
	localparam op_t OP_QUERY = 2'd1;
	localparam op_t OP_CLEAR = 2'd2;
	localparam op_t OP_LOAD  = 2'd3;

	// register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PPL      = 2'd0;
	localparam cfg_idx_t CFG_DEBOUNCE = 2'd1;
	localparam cfg_idx_t CFG_ENABLE   = 2'd2;

	localparam logic [PPL_W-1:0] PPL_RST      = 16'd450;
	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 20'd1000;

	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] time_us;
		logic [CNT_W-1:0] time_ms;
		logic [CNT_W-1:0] load_value;
	} item_t;

	typedef struct packed {
		logic             edge_counted;
		logic [CNT_W-1:0] total_pulses;
		logic [OUT_W-1:0] volume_q16;
		logic [OUT_W-1:0] flow_rate_q16;
		logic             rate_valid;
	} result_t;

	// work handed from the front to the divider
	typedef struct packed {
		logic             edge_counted;
		logic             rate_valid;
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] pulses;
		logic [CNT_W-1:0] elapsed;
		logic [PPL_W-1:0] ppl;
	} job_t;

	// queue handshake between the two halves
	typedef struct packed {
		logic push;
		logic full;
	} wr_ctl_t;

	typedef struct packed {
		logic pop;
		logic avail;
	} rd_ctl_t;

endpackage

/* rtl/fmpr_front.sv */
module fmpr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  fmpr_pkg::item_t             item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  fmpr_pkg::cfg_idx_t          cfg_index,
	input  logic [31:0]                 cfg_data,
	output fmpr_pkg::wr_ctl_t           wr_ctl,
	input  logic                        queue_full,
	output fmpr_pkg::job_t              job
);

	logic [fmpr_pkg::PPL_W-1:0] ppl_q;
	logic [fmpr_pkg::DEB_W-1:0] debounce_q;
	logic                       enable_q;

	logic [fmpr_pkg::CNT_W-1:0] total_q;
	logic [fmpr_pkg::CNT_W-1:0] base_pulses_q;
	logic [fmpr_pkg::CNT_W-1:0] base_ms_q;
	logic [fmpr_pkg::CNT_W-1:0] last_us_q;

	logic [fmpr_pkg::CNT_W-1:0] total_d;
	logic [fmpr_pkg::CNT_W-1:0] base_pulses_d;
	logic [fmpr_pkg::CNT_W-1:0] base_ms_d;
	logic [fmpr_pkg::CNT_W-1:0] last_us_d;
	logic [fmpr_pkg::CNT_W-1:0] since_us;
	logic [fmpr_pkg::CNT_W-1:0] elapsed;
	logic                       counted;
	logic                       rate_ok;
	logic                       accept;

	assign cfg_ready  = 1'b1;
	assign item_stall = queue_full;
	assign accept     = item_valid && !queue_full;

	assign since_us = item.time_us - last_us_q;
	assign elapsed  = item.time_ms - base_ms_q;

	always_comb begin
		total_d       = total_q;
		base_pulses_d = base_pulses_q;
		base_ms_d     = base_ms_q;
		last_us_d     = last_us_q;
		counted       = 1'b0;
		rate_ok       = 1'b0;
		unique case (item.op)
			fmpr_pkg::OP_EDGE: begin
				if (enable_q && (since_us >= {{(fmpr_pkg::CNT_W-fmpr_pkg::DEB_W){1'b0}},
						debounce_q})) begin
					counted   = 1'b1;
					total_d   = total_q + 32'd1;
					last_us_d = item.time_us;
				end
			end
			fmpr_pkg::OP_QUERY: begin
				// zero elapsed time leaves the baseline alone
				if (elapsed != '0) begin
					rate_ok       = 1'b1;
					base_pulses_d = total_q;
					base_ms_d     = item.time_ms;
				end
			end
			fmpr_pkg::OP_CLEAR: begin
				total_d       = '0;
				base_pulses_d = '0;
				base_ms_d     = item.time_ms;
			end
			fmpr_pkg::OP_LOAD: begin
				total_d       = item.load_value;
				base_pulses_d = item.load_value;
				base_ms_d     = item.time_ms;
			end
			default: begin
				total_d = total_q;
			end
		endcase
	end

	always_comb begin
		wr_ctl.push      = accept;
		wr_ctl.full      = queue_full;
		job.edge_counted = counted;
		job.rate_valid   = rate_ok;
		job.total        = total_d;
		job.pulses       = total_q - base_pulses_q;
		job.elapsed      = elapsed;
		job.ppl          = ppl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppl_q      <= fmpr_pkg::PPL_RST;
			debounce_q <= fmpr_pkg::DEBOUNCE_RST;
			enable_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fmpr_pkg::CFG_PPL:      ppl_q      <= cfg_data[fmpr_pkg::PPL_W-1:0];
				fmpr_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data[fmpr_pkg::DEB_W-1:0];
				fmpr_pkg::CFG_ENABLE:   enable_q   <= cfg_data[0];
				default:                enable_q   <= enable_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= '0;
			base_pulses_q <= '0;
			base_ms_q     <= '0;
			last_us_q     <= '0;
		end else if (accept) begin
			total_q       <= total_d;
			base_pulses_q <= base_pulses_d;
			base_ms_q     <= base_ms_d;
			last_us_q     <= last_us_d;
		end
	end

endmodule

/* rtl/fmpr_queue.sv */
module fmpr_queue #(
	parameter int DEPTH = fmpr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fmpr_pkg::wr_ctl_t wr_ctl,
	input  fmpr_pkg::job_t    wr_job,
	output logic              full,
	input  logic              pop,
	output fmpr_pkg::rd_ctl_t rd_ctl,
	output fmpr_pkg::job_t    rd_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	fmpr_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full        = (count_q == FULL_CNT);
	assign do_pop      = pop && (count_q != '0);
	assign rd_ctl.pop  = do_pop;
	assign rd_ctl.avail = (count_q != '0);
	assign rd_job      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_ctl.push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_ctl.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_ctl.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ctl.push |-> !full)
		else $error("push into full queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ctl.push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");

endmodule

/* rtl/fmpr_back.sv */
module fmpr_back #(
	parameter int FRAC_BITS = fmpr_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fmpr_pkg::rd_ctl_t rd_ctl,
	input  fmpr_pkg::job_t    job,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output fmpr_pkg::result_t result
);

	localparam int OW    = fmpr_pkg::OUT_W;
	localparam int PW    = fmpr_pkg::PPL_W;
	localparam int DIV_W = OW + FRAC_BITS;
	localparam int STEP_W = $clog2(DIV_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;

	// rate lane: 48-bit divisor
	logic [DIV_W-1:0] r_dvd_q;
	logic [OW-1:0]    r_den_q;
	logic [OW-1:0]    r_rem_q;
	logic [OW-1:0]    r_quo_q;
	logic             r_sat_q;
	// volume lane: 16-bit divisor
	logic [DIV_W-1:0] v_dvd_q;
	logic [PW-1:0]    v_den_q;
	logic [PW-1:0]    v_rem_q;
	logic [OW-1:0]    v_quo_q;
	logic             v_sat_q;

	logic             counted_q;
	logic             rate_ok_q;
	logic [fmpr_pkg::CNT_W-1:0] total_q;

	logic              res_valid_q;
	fmpr_pkg::result_t res_q;

	logic [OW:0]   r_part;
	logic          r_bit;
	logic [PW:0]   v_part;
	logic          v_bit;
	logic          out_free;
	logic [OW-1:0] rate_fin;
	logic [OW-1:0] vol_fin;

	assign out_free     = !res_valid_q || !result_stall;
	assign pop          = (state_q == ST_IDLE) && rd_ctl.avail;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// one restoring step per cycle in each lane
	assign r_part = {r_rem_q, r_dvd_q[DIV_W-1]};
	assign r_bit  = (r_part >= {1'b0, r_den_q});
	assign v_part = {v_rem_q, v_dvd_q[DIV_W-1]};
	assign v_bit  = (v_part >= {1'b0, v_den_q});

	assign rate_fin = r_sat_q ? fmpr_pkg::OUT_MAX : r_quo_q;
	assign vol_fin  = v_sat_q ? fmpr_pkg::OUT_MAX : v_quo_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			counted_q <= job.edge_counted;
			rate_ok_q <= job.rate_valid;
			total_q   <= job.total;
			r_dvd_q   <= {OW'(job.pulses * fmpr_pkg::MS_PER_MIN), {FRAC_BITS{1'b0}}};
			r_den_q   <= OW'(job.ppl * job.elapsed);
			r_rem_q   <= '0;
			r_quo_q   <= '0;
			r_sat_q   <= 1'b0;
			v_dvd_q   <= {{(OW-fmpr_pkg::CNT_W){1'b0}}, job.total, {FRAC_BITS{1'b0}}};
			v_den_q   <= job.ppl;
			v_rem_q   <= '0;
			v_quo_q   <= '0;
			v_sat_q   <= 1'b0;
		end else if (state_q == ST_RUN) begin
			r_dvd_q <= {r_dvd_q[DIV_W-2:0], 1'b0};
			r_rem_q <= r_bit ? OW'(r_part - {1'b0, r_den_q}) : r_part[OW-1:0];
			r_quo_q <= {r_quo_q[OW-2:0], r_bit};
			r_sat_q <= r_sat_q | r_quo_q[OW-1];
			v_dvd_q <= {v_dvd_q[DIV_W-2:0], 1'b0};
			v_rem_q <= v_bit ? PW'(v_part - {1'b0, v_den_q}) : v_part[PW-1:0];
			v_quo_q <= {v_quo_q[OW-2:0], v_bit};
			v_sat_q <= v_sat_q | v_quo_q[OW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			res_q.edge_counted  <= counted_q;
			res_q.total_pulses  <= total_q;
			res_q.volume_q16    <= vol_fin;
			res_q.flow_rate_q16 <= rate_ok_q ? rate_fin : '0;
			res_q.rate_valid    <= rate_ok_q;
		end
	end

	a_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.rate_valid) |-> (res_q.flow_rate_q16 == '0))
		else $error("rate reported without a valid query");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_RUN) && (step_q == '0))
		else $error("divider did not start after pop");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q != LAST_STEP) |=> (state_q == ST_RUN))
		else $error("divider left early");

endmodule

/* rtl/flow_meter_pulse_rate_unit.sv */
// Channel   Dir  Handshake             Payload
// item      in   item_valid/item_stall fmpr_pkg::item_t (op, time_us, time_ms, load_value)
// result    out  result_valid/stall    fmpr_pkg::result_t (one per item)
// cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data (ready held high)
//
// The front updates the pulse count and baselines in the cycle a request is
// accepted and pushes the work into a QUEUE_DEPTH-entry queue; requests are taken
// every cycle until the queue fills.
// The back runs two restoring dividers side by side, one quotient bit a cycle,
// FRAC_BITS + 48 steps; it takes the next job only once its last result is registered.
// Reset clears the count, baselines and queue and restores the register defaults.
// A stalled result is held in the output register while the back finishes the next one.
module flow_meter_pulse_rate_unit #(
	parameter int FRAC_BITS   = fmpr_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = fmpr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  fmpr_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output fmpr_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  fmpr_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]        cfg_data
);

	fmpr_pkg::wr_ctl_t wr_ctl;
	fmpr_pkg::rd_ctl_t rd_ctl;
	fmpr_pkg::job_t    wr_job;
	fmpr_pkg::job_t    rd_job;
	logic              queue_full;
	logic              pop;

	// classify the request and advance the count
	fmpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.wr_ctl     (wr_ctl),
		.queue_full (queue_full),
		.job        (wr_job)
	);

	// decouple the fast front from the slow divider
	fmpr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_ctl (wr_ctl),
		.wr_job (wr_job),
		.full   (queue_full),
		.pop    (pop),
		.rd_ctl (rd_ctl),
		.rd_job (rd_job)
	);

	// scale volume and rate, then hold the result until taken
	fmpr_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_ctl       (rd_ctl),
		.job          (rd_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
